[hdl/apcs_pkg.sv]
// ----------------------------------------------------------------------------
// apcs_pkg
// Shared types, codes and colour helpers for the attribute pixel serializer.
// ----------------------------------------------------------------------------
package apcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int EXT_DEPTH     = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 4;

  // Input item command codes. Code three has no meaning and is dropped.
  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_PAL_WR = 2'd1,
    CMD_EXT_WR = 2'd2
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_GROUP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENDED_MODEL  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENDED_ENABLE = 2'd2;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  pixel_byte;
    logic [7:0]  attr_byte;
    logic        flash_phase;
    logic [7:0]  table_index;
    logic [31:0] table_value;
  } cell_item_t;

  typedef struct packed {
    logic [31:0] colour;
    logic [2:0]  pixel_pos;
    logic        last;
  } pixel_item_t;

  // Replicate a 3-bit component across eight bits.
  function automatic logic [7:0] expand3(input logic [2:0] v);
    expand3 = {v, v, v[2:1]};
  endfunction

  // Two-bit blue to eight bits; model two uses a darker third step.
  function automatic logic [7:0] expand_blue(input logic [1:0] b, input logic model_two);
    logic [7:0] res;
    case (b)
      2'd0:    res = 8'h00;
      2'd1:    res = 8'h6D;
      2'd2:    res = model_two ? 8'h92 : 8'hB6;
      default: res = 8'hFF;
    endcase
    expand_blue = res;
  endfunction

  // G3R3B2 byte to 0x00RRGGBB.
  function automatic logic [31:0] g3r3b2_to_rgb(input logic [7:0] c, input logic model_two);
    g3r3b2_to_rgb = {8'h00, expand3(c[4:2]), expand3(c[7:5]), expand_blue(c[1:0], model_two)};
  endfunction

endpackage

[hdl/apcs_ram.sv]
// ----------------------------------------------------------------------------
// apcs_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module apcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = apcs_pkg::PALETTE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[hdl/attribute_pixel_colour_serializer_core.sv]
// ----------------------------------------------------------------------------
// attribute_pixel_colour_serializer_core
// Decodes one screen cell (pixel byte plus attribute byte) into eight pixel
// colours, from a main palette or from an extended G3R3B2 colour store.
// ----------------------------------------------------------------------------
//
//   channel   signals                                   carries
//   cell      cell_valid / cell_stall / cell_item       one command item
//   pixel     pixel_valid / pixel_stall / pixel         one pixel colour
//   cfg       cfg_valid / cfg_ready / cfg_index/data    register write
//
// A draw item yields eight pixels, one per cycle while the output is not
// stalled; the next cell can wait decoded behind the run, so runs can follow
// back to back. Write items yield no pixels. When the pipe is empty the
// first pixel of a cell passes the registered memory read, loaded at the
// edge that accepts the cell, and then the output register, which the
// colour expansion loads. Reset (rst, synchronous) clears the valid flags
// and the configuration registers.
// A stalled pixel output holds; a cell is stalled only while a decoded cell
// already waits behind a pixel run that is not finishing this cycle.
//
module attribute_pixel_colour_serializer_core #(
  parameter int PALETTE_DEPTH = apcs_pkg::PALETTE_DEPTH,
  parameter int EXT_DEPTH     = apcs_pkg::EXT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cell_valid,
  output logic                              cell_stall,
  input  apcs_pkg::cell_item_t              cell_item,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output apcs_pkg::pixel_item_t             pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [apcs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [apcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import apcs_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int EXT_AW = $clog2(EXT_DEPTH);

  // Configuration registers.
  logic [3:0] palette_group;
  logic [1:0] extended_model;
  logic       extended_enable;

  // Handshake qualifiers.
  logic cell_acc;
  logic draw_acc;
  logic pixel_acc;
  logic ext_mode;

  // Decode stage: the memory read data belongs to this cell.
  logic       s1_valid;
  logic       s1_ext;
  logic [7:0] s1_pix;
  logic       s1_move;

  // Serializer stage, which is also the output register.
  logic        ser_valid;
  logic [31:0] ser_ink;
  logic [31:0] ser_paper;
  logic [7:0]  ser_pix;
  logic [2:0]  ser_pos;
  logic        ser_free;

  // Memory ports.
  logic [PAL_AW-1:0] pal_ink_addr;
  logic [PAL_AW-1:0] pal_paper_addr;
  logic [EXT_AW-1:0] ext_ink_addr;
  logic [EXT_AW-1:0] ext_paper_addr;
  logic [31:0]       pal_ink_data;
  logic [31:0]       pal_paper_data;
  logic [7:0]        ext_ink_data;
  logic [7:0]        ext_paper_data;
  logic [31:0]       ink_colour;
  logic [31:0]       paper_colour;
  logic [7:0]        pix_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_group   <= '0;
      extended_model  <= '0;
      extended_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PALETTE_GROUP:   palette_group   <= cfg_data[3:0];
        REG_EXTENDED_MODEL:  extended_model  <= cfg_data[1:0];
        REG_EXTENDED_ENABLE: extended_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Extended colours are used only when a model is fitted and software has
  // switched the mode on.
  assign ext_mode = (extended_model != 2'd0) && extended_enable;

  assign pixel_acc = pixel_valid && !pixel_stall;
  assign ser_free  = !ser_valid || (pixel_acc && pixel.last);
  assign s1_move   = s1_valid && ser_free;
  assign cell_stall = s1_valid && !ser_free;
  assign cell_acc  = cell_valid && !cell_stall;
  assign draw_acc  = cell_acc && (cell_item.command == CMD_DRAW);

  // Normal mode: group in the top nibble, bright, then the 3-bit colour.
  // Extended mode: attribute flash and bright pick one of four groups of
  // sixteen, ink in the lower eight and paper in the upper eight.
  assign pal_ink_addr   = PAL_AW'({palette_group, cell_item.attr_byte[6],
                                   cell_item.attr_byte[2:0]});
  assign pal_paper_addr = PAL_AW'({palette_group, cell_item.attr_byte[6],
                                   cell_item.attr_byte[5:3]});
  assign ext_ink_addr   = EXT_AW'({cell_item.attr_byte[7:6], 1'b0, cell_item.attr_byte[2:0]});
  assign ext_paper_addr = EXT_AW'({cell_item.attr_byte[7:6], 1'b1, cell_item.attr_byte[5:3]});

  // Flash inverts the pixels only in normal mode.
  assign pix_eff = (!ext_mode && cell_item.attr_byte[7] && cell_item.flash_phase) ?
                   ~cell_item.pixel_byte : cell_item.pixel_byte;

  apcs_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_main_palette (
    .clk       (clk),
    .wr_en     (cell_acc && (cell_item.command == CMD_PAL_WR)),
    .wr_addr   (cell_item.table_index[PAL_AW-1:0]),
    .wr_data   (cell_item.table_value),
    .rd_en     (draw_acc),
    .rd_addr_a (pal_ink_addr),
    .rd_addr_b (pal_paper_addr),
    .rd_data_a (pal_ink_data),
    .rd_data_b (pal_paper_data)
  );

  apcs_ram #(
    .WIDTH (8),
    .DEPTH (EXT_DEPTH)
  ) u_ext_colours (
    .clk       (clk),
    .wr_en     (cell_acc && (cell_item.command == CMD_EXT_WR)),
    .wr_addr   (cell_item.table_index[EXT_AW-1:0]),
    .wr_data   (cell_item.table_value[7:0]),
    .rd_en     (draw_acc),
    .rd_addr_a (ext_ink_addr),
    .rd_addr_b (ext_paper_addr),
    .rd_data_a (ext_ink_data),
    .rd_data_b (ext_paper_data)
  );

  // The read data holds until the next draw is accepted, so a cell can wait
  // in the decode stage while the previous run drains. A write lands in the
  // memory at its own accept edge, before any later draw reads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (draw_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_acc) begin
      s1_ext <= ext_mode;
      s1_pix <= pix_eff;
    end
  end

  assign ink_colour   = s1_ext ? g3r3b2_to_rgb(ext_ink_data, extended_model[1]) : pal_ink_data;
  assign paper_colour = s1_ext ? g3r3b2_to_rgb(ext_paper_data, extended_model[1]) :
                        pal_paper_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
    end else if (s1_move) begin
      ser_valid <= 1'b1;
    end else if (pixel_acc && pixel.last) begin
      ser_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ser_ink   <= ink_colour;
      ser_paper <= paper_colour;
      ser_pix   <= s1_pix;
      ser_pos   <= '0;
    end else if (pixel_acc) begin
      ser_pix <= {ser_pix[6:0], 1'b0};
      ser_pos <= ser_pos + 3'd1;
    end
  end

  assign pixel_valid     = ser_valid;
  assign pixel.colour    = ser_pix[7] ? ser_ink : ser_paper;
  assign pixel.pixel_pos = ser_pos;
  assign pixel.last      = (ser_pos == 3'd7);

  // Within a run the position advances by one per delivered pixel.
  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    (pixel_acc && !pixel.last) |=>
      (pixel_valid && (pixel.pixel_pos == 3'($past(pixel.pixel_pos) + 3'd1))))
    else $error("pixel position did not advance within a cell");

  // A cell is never taken while the decode stage is full and stays full.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cell_acc |-> (!s1_valid || s1_move))
    else $error("cell accepted over an occupied decode stage");

  // Each run starts at the leftmost pixel.
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> (pixel_valid && (pixel.pixel_pos == 3'd0)))
    else $error("pixel run did not start at position zero");

endmodule

[verif/attribute_pixel_colour_serializer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_pixel_colour_serializer_core_test
// Self-checking bench for the cell colour serializer. It drives draw and
// store-write items, writes the mode registers between phases, predicts the
// eight pixel colours of every drawn cell and checks them in order.
// ----------------------------------------------------------------------------
module attribute_pixel_colour_serializer_core_test;
  import apcs_pkg::*;

  // Command code three carries no meaning; the block must drop it silently.
  localparam cmd_t CMD_UNUSED = cmd_t'(2'd3);
  // Register index three selects no register and must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  // Even with the receiver stalling most of the time a correct run ends well
  // within this limit, so it only trips on a hang.
  localparam int CYCLE_LIMIT = 400000;
  // Extra wait after the last predicted pixel, before the registers are touched.
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 36;

  // Keeps a shadow copy of both colour stores and the mode registers. It
  // turns every accepted cell into the pixels it must produce and checks
  // each accepted pixel against the oldest one still waiting.
  class cell_colour_predictor;
    logic [31:0] palette [PALETTE_DEPTH];
    logic [7:0]  ext_colours [EXT_DEPTH];
    bit          palette_loaded [PALETTE_DEPTH];
    bit          ext_loaded [EXT_DEPTH];
    logic [3:0]  group;
    logic [1:0]  model;
    logic        enable;
    pixel_item_t pending_pixels [$];
    int          mismatches;

    function new();
      group = '0;
      model = '0;
      enable = 1'b0;
      mismatches = 0;
    endfunction

    function bit extended_on();
      return (model != 2'd0) && enable;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PALETTE_GROUP:   group = data;
        REG_EXTENDED_MODEL:  model = data[1:0];
        REG_EXTENDED_ENABLE: enable = data[0];
        default: ;
      endcase
    endfunction

    // Red and green repeat their three bits; blue follows the selected model,
    // where model code three behaves as model two.
    function logic [31:0] rgb_from_g3r3b2(logic [7:0] c);
      logic [7:0] red, green, blue;
      red   = {c[4:2], 5'b0} | {3'b0, c[4:2], 2'b0} | {6'b0, c[4:3]};
      green = {c[7:5], 5'b0} | {3'b0, c[7:5], 2'b0} | {6'b0, c[7:6]};
      case (c[1:0])
        2'd0:    blue = 8'h00;
        2'd1:    blue = 8'h6D;
        2'd2:    blue = model[1] ? 8'h92 : 8'hB6;
        default: blue = 8'hFF;
      endcase
      return {8'h00, red, green, blue};
    endfunction

    function void note_cell(cell_item_t it);
      logic [31:0] ink, paper;
      logic [7:0]  bits;
      pixel_item_t px;
      case (it.command)
        CMD_PAL_WR: begin
          palette[it.table_index] = it.table_value;
          palette_loaded[it.table_index] = 1'b1;
        end
        CMD_EXT_WR: begin
          ext_colours[it.table_index[5:0]] = it.table_value[7:0];
          ext_loaded[it.table_index[5:0]] = 1'b1;
        end
        CMD_DRAW: begin
          bits = it.pixel_byte;
          if (extended_on()) begin
            // Flash and bright pick one of four groups of sixteen; no inversion.
            ink   = rgb_from_g3r3b2(ext_colours[{it.attr_byte[7:6], 1'b0, it.attr_byte[2:0]}]);
            paper = rgb_from_g3r3b2(ext_colours[{it.attr_byte[7:6], 1'b1, it.attr_byte[5:3]}]);
          end else begin
            if (it.attr_byte[7] && it.flash_phase) begin
              bits = ~bits;
            end
            ink   = palette[{group, it.attr_byte[6], it.attr_byte[2:0]}];
            paper = palette[{group, it.attr_byte[6], it.attr_byte[5:3]}];
          end
          for (int k = 0; k < 8; k++) begin
            px.colour    = bits[7 - k] ? ink : paper;
            px.pixel_pos = 3'(k);
            px.last      = (k == 7);
            pending_pixels.push_back(px);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(pixel_item_t got);
      pixel_item_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, colour %h pos %0d last %0b",
                 $time, got.colour, got.pixel_pos, got.last);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.colour !== want.colour) begin
        $display("%0t: colour expected %h got %h", $time, want.colour, got.colour);
        mismatches++;
      end
      if (got.pixel_pos !== want.pixel_pos) begin
        $display("%0t: pixel_pos expected %0d got %0d", $time, want.pixel_pos, got.pixel_pos);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cell_valid = 1'b0;
  logic                   cell_stall;
  cell_item_t             cell_item = '0;
  logic                   pixel_valid;
  logic                   pixel_stall = 1'b0;
  pixel_item_t            pixel;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct = 0;
  // Counts accepted items that mean something; dropped commands are left out.
  int cells_sent = 0;
  int cycle_count = 0;

  cell_colour_predictor predictor;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  attribute_pixel_colour_serializer_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cell_valid  (cell_valid),
    .cell_stall  (cell_stall),
    .cell_item   (cell_item),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Pixel receiver. Values read right after the edge are the ones the block
  // saw at that edge, so a pixel counts as taken when valid was high and our
  // stall was low. The stall for the next edge is then drawn at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        predictor.check_pixel(pixel);
      end
      pixel_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a block that hangs or loses pixels ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Every field gets random bits, so the fields a command ignores toggle too.
  function automatic cell_item_t random_cell(cmd_t cmd);
    cell_item_t it;
    it.command     = cmd;
    it.pixel_byte  = 8'($urandom);
    it.attr_byte   = 8'($urandom);
    it.flash_phase = 1'($urandom);
    it.table_index = 8'($urandom);
    it.table_value = $urandom;
    return it;
  endfunction

  // Offers one item after a random idle gap and returns at the edge that takes
  // it. Valid is only lowered when a gap follows, so back-to-back items keep
  // it high without a second assignment in the same step.
  task automatic send_cell(input cell_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_item <= it;
    cell_valid <= 1'b1;
    @(posedge clk);
    while (cell_stall) begin
      @(posedge clk);
    end
    predictor.note_cell(it);
    if (it.command != CMD_UNUSED) begin
      cells_sent++;
    end
  endtask

  task automatic write_entry(input cmd_t cmd, input logic [7:0] idx, input logic [31:0] value);
    cell_item_t it;
    it = random_cell(cmd);
    it.table_index = idx;
    it.table_value = value;
    send_cell(it);
  endtask

  // The stores power up undefined, so every entry a draw reads is loaded
  // first. For the extended store the two unused index bits stay random.
  task automatic load_entry(input bit ext, input logic [7:0] idx);
    if (ext) begin
      write_entry(CMD_EXT_WR, {2'($urandom), idx[5:0]}, $urandom);
    end else begin
      write_entry(CMD_PAL_WR, idx, $urandom);
    end
  endtask

  task automatic draw_cell(input logic [7:0] pix, input logic [7:0] attr, input logic phase);
    cell_item_t it;
    logic [7:0] ink_idx, paper_idx;
    bit ext;
    ext = predictor.extended_on();
    if (ext) begin
      ink_idx   = {2'b00, attr[7:6], 1'b0, attr[2:0]};
      paper_idx = {2'b00, attr[7:6], 1'b1, attr[5:3]};
    end else begin
      ink_idx   = {predictor.group, attr[6], attr[2:0]};
      paper_idx = {predictor.group, attr[6], attr[5:3]};
    end
    if (ext ? !predictor.ext_loaded[ink_idx[5:0]] : !predictor.palette_loaded[ink_idx]) begin
      load_entry(ext, ink_idx);
    end
    if (ext ? !predictor.ext_loaded[paper_idx[5:0]] : !predictor.palette_loaded[paper_idx]) begin
      load_entry(ext, paper_idx);
    end
    it = random_cell(CMD_DRAW);
    it.pixel_byte  = pix;
    it.attr_byte   = attr;
    it.flash_phase = phase;
    send_cell(it);
  endtask

  // Holds the write until the block takes it. Valid stays high so that a run
  // of writes goes out back to back; the caller lowers it afterwards.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    predictor.write_register(idx, data);
  endtask

  // The bits above the model and enable fields carry random values and must be ignored.
  task automatic configure(input logic [3:0] group, input logic [1:0] model, input logic enable);
    write_register(REG_PALETTE_GROUP, group);
    write_register(REG_EXTENDED_MODEL, {2'($urandom), model});
    write_register(REG_EXTENDED_ENABLE, {3'($urandom), enable});
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits for every predicted pixel. A trailing write
  // yields nothing to wait for, so a fixed drain follows before the
  // registers may be touched.
  task automatic settle();
    cell_valid <= 1'b0;
    while (predictor.pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly draws of fully loaded cells, with store writes mixed in to change
  // colours under the draws and a few dropped commands as noise.
  task automatic random_phase(input int count);
    int start;
    int pick;
    start = cells_sent;
    while (cells_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        draw_cell(8'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 80) begin
        send_cell(random_cell(CMD_PAL_WR));
      end else if (pick < 95) begin
        send_cell(random_cell(CMD_EXT_WR));
      end else begin
        send_cell(random_cell(CMD_UNUSED));
      end
    end
  endtask

  initial begin
    predictor = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 32;
    stall_pct = 86;

    // A write to the empty register slot must not disturb the real ones.
    write_register(REG_NONE, 4'($urandom));
    configure(4'h0, 2'd0, 1'b0);

    // Normal mode: all paper, all ink, a flashing cell in both phases and a
    // bright cell, with the palette extremes loaded where they are read.
    write_entry(CMD_PAL_WR, 8'h00, 32'h0000_0000);
    write_entry(CMD_PAL_WR, 8'h07, 32'hFFFF_FFFF);
    write_entry(CMD_PAL_WR, 8'hFF, 32'hFFFF_FFFF);
    draw_cell(8'h00, 8'h00, 1'b0);
    draw_cell(8'hFF, 8'h07, 1'b1);
    draw_cell(8'hA5, 8'hB8, 1'b1);
    draw_cell(8'hA5, 8'hB8, 1'b0);
    draw_cell(8'h3C, 8'h7F, 1'b1);
    send_cell(random_cell(CMD_UNUSED));

    // Enable without a model leaves the block in normal mode; top group.
    settle();
    configure(4'hF, 2'd0, 1'b1);
    draw_cell(8'h5A, 8'hC7, 1'b1);
    draw_cell(8'hC3, 8'hFF, 1'b0);

    // Extended mode with blue model one. The upper index bits of an extended
    // write are ignored, and a flashing cell keeps its pixels.
    settle();
    configure(4'hA, 2'd1, 1'b1);
    write_entry(CMD_EXT_WR, 8'hC0, 32'hFFFF_FF02);
    write_entry(CMD_EXT_WR, 8'h08, 32'h0000_00FF);
    write_entry(CMD_EXT_WR, 8'h3F, 32'h1234_56E1);
    draw_cell(8'h96, 8'h00, 1'b1);
    draw_cell(8'h81, 8'hFF, 1'b1);

    // Model code three must give the blue of model two for the same entries.
    settle();
    configure(4'h5, 2'd3, 1'b1);
    draw_cell(8'h96, 8'h00, 1'b0);
    draw_cell(8'h81, 8'hFF, 1'b1);

    // Random phases, each under its own register setting. The first two
    // stall mostly at the receiver, the next two mostly at the sender, and
    // the last two run at full rate.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 86;
        stall_pct = 32;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      settle();
      case (p)
        0:       configure(4'hF, 2'd0, 1'b1);
        1:       configure(4'($urandom), 2'd1, 1'b1);
        2:       configure(4'h0, 2'd2, 1'b1);
        3:       configure(4'($urandom), 2'd3, 1'b1);
        4:       configure(4'($urandom), 2'd2, 1'b0);
        default: configure(4'($urandom), 2'd1, 1'b1);
      endcase
      random_phase(ITEMS_PER_PHASE);
    end

    settle();
    if (predictor.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
